>>> rtl/offset_utf_char_decoder_defines.svh
// ----------------------------------------------------------------------------
// offset_utf_char_decoder_defines.svh
// Assertion macros used by the decoder's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef OFFSET_UTF_CHAR_DECODER_DEFINES_SVH
`define OFFSET_UTF_CHAR_DECODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside of reset.
`define OFSUTF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside of reset.
`define OFSUTF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ofsutf_pkg.sv
// ----------------------------------------------------------------------------
// ofsutf_pkg
// Types, status codes and offsets of the offset UTF character decoder.
// ----------------------------------------------------------------------------
package ofsutf_pkg;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_END = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic [2:0] MAX_BYTES = 3'd5;

  localparam logic [30:0] OFFSET_2 = 31'h0000080;
  localparam logic [30:0] OFFSET_3 = 31'h0002080;
  localparam logic [30:0] OFFSET_4 = 31'h0082080;
  localparam logic [30:0] OFFSET_5 = 31'h2082080;

  // Classified window: form length, early status and the payload bits.
  typedef struct packed {
    logic [2:0] len;
    logic [1:0] st;
    logic [6:0] lead;
    logic [6:0] cont_1;
    logic [6:0] cont_2;
    logic [6:0] cont_3;
    logic [6:0] cont_4;
  } ofsutf_cls_t;

  // Assembled payload before the length offset is added.
  typedef struct packed {
    logic [2:0]  len;
    logic [1:0]  st;
    logic [30:0] acc;
  } ofsutf_asm_t;

  // Final result.
  typedef struct packed {
    logic [30:0] code_point;
    logic [2:0]  used_bytes;
    logic [1:0]  status;
  } ofsutf_res_t;

endpackage

>>> rtl/ofsutf_classify.sv
// ----------------------------------------------------------------------------
// ofsutf_classify
// First stage: finds the form length from the lead byte and checks the window.
// ----------------------------------------------------------------------------
module ofsutf_classify (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  input  logic [7:0]               byte_0,
  input  logic [7:0]               byte_1,
  input  logic [7:0]               byte_2,
  input  logic [7:0]               byte_3,
  input  logic [7:0]               byte_4,
  input  logic [2:0]               avail_bytes,
  output logic                     ready_o,
  input  logic                     ready_i,
  output logic                     valid_o,
  output ofsutf_pkg::ofsutf_cls_t  data_o
);
  import ofsutf_pkg::*;

  logic        valid_r;
  ofsutf_cls_t data_r;
  ofsutf_cls_t data_nxt;
  logic [2:0]  avail;
  logic        cont_bad;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_comb begin
    avail = (avail_bytes > MAX_BYTES) ? MAX_BYTES : avail_bytes;

    data_nxt.lead   = byte_0[6:0];
    data_nxt.cont_1 = byte_1[6:0];
    data_nxt.cont_2 = byte_2[6:0];
    data_nxt.cont_3 = byte_3[6:0];
    data_nxt.cont_4 = byte_4[6:0];

    // The form length is set by the position of the first clear bit of the lead.
    if (!byte_0[7]) begin
      data_nxt.len = 3'd1;
    end else if (!byte_0[6]) begin
      data_nxt.len = 3'd2;
    end else if (!byte_0[5]) begin
      data_nxt.len = 3'd3;
    end else if (!byte_0[4]) begin
      data_nxt.len = 3'd4;
    end else if (!byte_0[3]) begin
      data_nxt.len = 3'd5;
    end else begin
      data_nxt.len = 3'd0;
    end

    // Every byte that the form needs past the lead must have its top bit set.
    cont_bad = ((data_nxt.len > 3'd1) && !byte_1[7]) ||
               ((data_nxt.len > 3'd2) && !byte_2[7]) ||
               ((data_nxt.len > 3'd3) && !byte_3[7]) ||
               ((data_nxt.len > 3'd4) && !byte_4[7]);

    if (avail == 3'd0 || byte_0 == 8'd0) begin
      data_nxt.st = ST_END;
    end else if (data_nxt.len == 3'd0 || avail < data_nxt.len || cont_bad) begin
      data_nxt.st = ST_BAD;
    end else begin
      data_nxt.st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> rtl/ofsutf_assemble.sv
// ----------------------------------------------------------------------------
// ofsutf_assemble
// Second stage: packs the lead and continuation payload bits into one value.
// ----------------------------------------------------------------------------
module ofsutf_assemble (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  input  ofsutf_pkg::ofsutf_cls_t  data_i,
  output logic                     ready_o,
  input  logic                     ready_i,
  output logic                     valid_o,
  output ofsutf_pkg::ofsutf_asm_t  data_o
);
  import ofsutf_pkg::*;

  logic        valid_r;
  ofsutf_asm_t data_r;
  ofsutf_asm_t data_nxt;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_comb begin
    data_nxt.len = data_i.len;
    data_nxt.st  = data_i.st;
    case (data_i.len)
      3'd1:    data_nxt.acc = {24'd0, data_i.lead};
      3'd2:    data_nxt.acc = {18'd0, data_i.lead[5:0], data_i.cont_1};
      3'd3:    data_nxt.acc = {12'd0, data_i.lead[4:0], data_i.cont_1, data_i.cont_2};
      3'd4:    data_nxt.acc = {6'd0, data_i.lead[3:0], data_i.cont_1, data_i.cont_2,
                               data_i.cont_3};
      3'd5:    data_nxt.acc = {data_i.lead[2:0], data_i.cont_1, data_i.cont_2,
                               data_i.cont_3, data_i.cont_4};
      default: data_nxt.acc = 31'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> rtl/ofsutf_offset.sv
// ----------------------------------------------------------------------------
// ofsutf_offset
// Third stage: adds the length offset, checks the range and holds the result.
// ----------------------------------------------------------------------------
module ofsutf_offset (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  input  ofsutf_pkg::ofsutf_asm_t  data_i,
  output logic                     ready_o,
  input  logic                     ready_i,
  output logic                     valid_o,
  output ofsutf_pkg::ofsutf_res_t  data_o
);
  import ofsutf_pkg::*;

  logic        valid_r;
  ofsutf_res_t data_r;
  ofsutf_res_t data_nxt;
  logic [30:0] offset;
  logic [31:0] sum;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_comb begin
    case (data_i.len)
      3'd2:    offset = OFFSET_2;
      3'd3:    offset = OFFSET_3;
      3'd4:    offset = OFFSET_4;
      3'd5:    offset = OFFSET_5;
      default: offset = 31'd0;
    endcase
    sum = {1'b0, data_i.acc} + {1'b0, offset};

    // A carry into bit 31 means the value does not fit in 31 bits.
    if (data_i.st == ST_OK && !sum[31]) begin
      data_nxt.code_point = sum[30:0];
      data_nxt.used_bytes = data_i.len;
      data_nxt.status     = ST_OK;
    end else begin
      data_nxt.code_point = 31'd0;
      data_nxt.used_bytes = 3'd0;
      data_nxt.status     = (data_i.st == ST_END) ? ST_END : ST_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> rtl/offset_utf_char_decoder.sv
// ----------------------------------------------------------------------------
// offset_utf_char_decoder
// Decodes one offset-form UTF character per transaction from a 5-byte window.
// ----------------------------------------------------------------------------
// The input channel carries a window of five bytes and a count of valid bytes;
// the output channel returns one result per input transaction: the code point,
// the number of bytes used and a status (decoded, end, malformed).
// Both channels use valid/stall; a transaction completes on a rising edge with
// valid high and stall low.
// The decoder is a three-stage pipeline: classify the lead byte and check the
// window, assemble the payload bits, then add the length offset and check the
// range. Each input is registered in the classify, assemble and offset stages
// in turn; the offset stage's register drives the output result.
// With no stall on the output, one transaction is taken and one result given
// every cycle. The pipeline has no kept state; throughput is set by the single
// register per stage.
// When out_stall is high, the held result stays stable and earlier stages fill
// their empty slots; in_stall rises only once every stage holds an item.
// Reset (rst_n low, synchronous) empties every stage; no result is pending
// afterwards.
// ----------------------------------------------------------------------------
`include "offset_utf_char_decoder_defines.svh"

module offset_utf_char_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_0,
  input  logic [7:0]  in_byte_1,
  input  logic [7:0]  in_byte_2,
  input  logic [7:0]  in_byte_3,
  input  logic [7:0]  in_byte_4,
  input  logic [2:0]  in_avail_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_code_point,
  output logic [2:0]  out_used_bytes,
  output logic [1:0]  out_status
);
  import ofsutf_pkg::*;

  logic        cls_ready;
  logic        cls_valid;
  ofsutf_cls_t cls_data;
  logic        asm_ready;
  logic        asm_valid;
  ofsutf_asm_t asm_data;
  logic        off_ready;
  ofsutf_res_t res_data;

  ofsutf_classify u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (in_valid),
    .byte_0      (in_byte_0),
    .byte_1      (in_byte_1),
    .byte_2      (in_byte_2),
    .byte_3      (in_byte_3),
    .byte_4      (in_byte_4),
    .avail_bytes (in_avail_bytes),
    .ready_o     (cls_ready),
    .ready_i     (asm_ready),
    .valid_o     (cls_valid),
    .data_o      (cls_data)
  );

  ofsutf_assemble u_assemble (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (cls_valid),
    .data_i  (cls_data),
    .ready_o (asm_ready),
    .ready_i (off_ready),
    .valid_o (asm_valid),
    .data_o  (asm_data)
  );

  ofsutf_offset u_offset (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (asm_valid),
    .data_i  (asm_data),
    .ready_o (off_ready),
    .ready_i (!out_stall),
    .valid_o (out_valid),
    .data_o  (res_data)
  );

  assign in_stall       = !cls_ready;
  assign out_code_point = res_data.code_point;
  assign out_used_bytes = res_data.used_bytes;
  assign out_status     = res_data.status;

  `OFSUTF_ASSERT_IMP(a_fail_zero, out_valid && out_status != ST_OK,
    out_code_point == 31'd0 && out_used_bytes == 3'd0,
    "non-decoded result carries a value or byte count")

  `OFSUTF_ASSERT_IMP(a_ok_used, out_valid && out_status == ST_OK,
    out_used_bytes != 3'd0 && out_used_bytes <= MAX_BYTES,
    "decoded result has a bad byte count")

  `OFSUTF_ASSERT_IMP(a_one_byte, out_valid && out_status == ST_OK && out_used_bytes == 3'd1,
    out_code_point != 31'd0 && out_code_point < 31'h80,
    "one-byte result out of range")

  `OFSUTF_ASSERT_IMP(a_two_byte, out_valid && out_status == ST_OK && out_used_bytes == 3'd2,
    out_code_point >= OFFSET_2 && out_code_point < OFFSET_3,
    "two-byte result out of range")

  `OFSUTF_ASSERT_IMP(a_empty_ready, !out_valid, !in_stall,
    "input stalled while the pipeline is not full")

  `OFSUTF_ASSERT_NXT(a_status_code, in_valid, !out_valid || out_status != 2'd3,
    "undefined status code")

endmodule
